FILE: rtl/core/pde_pkg.sv
// Package for the phase difference estimator: widths, register indexes and
// the CORDIC arctangent table. Depends on nothing; all but pde_in_if use it.

package pde_pkg;

    localparam int COEF_W      = 16;
    localparam int PHASE_W     = 16;
    localparam int Z_W         = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int ATAN_N      = 24;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_REAL = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_IMAG = 8'd1;

    // Reset value of the coefficient: one in Q2.14, i.e. no rotation
    localparam logic signed [COEF_W-1:0] COEF_REAL_RST = 16'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_IMAG_RST = 16'sd0;

    // Angle accumulator: 2^31 stands for pi
    localparam logic [Z_W-1:0] Z_PI       = 32'h8000_0000;
    localparam logic [Z_W-1:0] Z_ZERO     = 32'h0000_0000;
    localparam logic [Z_W-1:0] ROUND_HALF = 32'h0000_8000;

    // atan(2^-i) scaled so that 2^31 is pi
    localparam logic [Z_W-1:0] ATAN_TAB [0:ATAN_N-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

FILE: rtl/core/pde_in_if.sv
// Sample-pair request channel of the phase difference estimator.
// Valid/ready handshake; carries reference and second-channel I/Q samples.

interface pde_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] ref_real;
    logic signed [SAMPLE_WIDTH-1:0] ref_imag;
    logic signed [SAMPLE_WIDTH-1:0] sig_real;
    logic signed [SAMPLE_WIDTH-1:0] sig_imag;

    modport source (output valid, ref_real, ref_imag, sig_real, sig_imag, input ready);
    modport sink   (input valid, ref_real, ref_imag, sig_real, sig_imag, output ready);
endinterface

FILE: rtl/core/pde_out_if.sv
// Phase result channel of the phase difference estimator.
// Valid/ready handshake; width of the phase taken from pde_pkg.

interface pde_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pde_pkg::PHASE_W-1:0]   phase;

    modport source (output valid, phase, input ready);
    modport sink   (input valid, phase, output ready);
endinterface

FILE: rtl/core/pde_cfg_if.sv
// Configuration write channel of the phase difference estimator.
// Valid/ready handshake carrying a register index and write data (pde_pkg).

interface pde_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pde_pkg::CFG_INDEX_W-1:0]    index;
    logic [pde_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/phase_difference_estimator.sv
// Phase difference estimator: conjugate product, coefficient rotation and
// CORDIC vectoring to a binary-radian angle. Uses pde_pkg and the pde_*_if
// channel interfaces.
//
// Usage
//  - sample_in takes one request per cycle while ready: a reference I/Q sample
//    and a second-channel I/Q sample. phase_out returns one request per input,
//    in order: the angle of ref * conj(sig) * coef, 32768 = pi, wrapping; a
//    zero vector gives 0.
//  - cfg writes the coefficient (index 0 real, 1 imaginary, Q2.14); any other
//    index is dropped. cfg is always ready. Write it only while no request is
//    in flight.
//  - Pipeline: five setup stages (sample products, conjugate sum, coefficient
//    products, rotation sum, half-plane fold), one stage per CORDIC
//    micro-rotation and one rounding stage.
//  - Throughput: one request per cycle while the skid register is empty, set
//    by the fully pipelined datapath.
//  - Reset clears every valid bit and loads the coefficient with one (no
//    rotation); results come out on the first request after reset.
//  - Stalls: a one-entry skid register catches the result that the receiver
//    refuses; sample_in.ready drops only while that register is full, and
//    the whole pipeline then holds. Nothing is lost or repeated.

module phase_difference_estimator #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pde_in_if.sink     sample_in,
    pde_out_if.source  phase_out,
    pde_cfg_if.sink    cfg
);

    // Product shift for wide samples keeps the conjugate product in range
    localparam int PS  = (SAMPLE_WIDTH > 16) ? 2 * (SAMPLE_WIDTH - 16) : 0;
    localparam int MW  = 2 * SAMPLE_WIDTH;              // one sample product
    localparam int SW  = MW + 1;                        // sum of two products
    localparam int PW  = SW - PS;                       // conjugate product part
    localparam int CMW = PW + pde_pkg::COEF_W;          // product times coef
    localparam int QW  = CMW + 1;                       // rotated part
    localparam int XW  = QW + 2;                        // CORDIC x/y with growth
    localparam int NS  = (CORDIC_STEPS < pde_pkg::ATAN_N) ? CORDIC_STEPS
                                                           : pde_pkg::ATAN_N;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [pde_pkg::COEF_W-1:0] coef_real_reg;
    logic signed [pde_pkg::COEF_W-1:0] coef_imag_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_real_reg <= pde_pkg::COEF_REAL_RST;
            coef_imag_reg <= pde_pkg::COEF_IMAG_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pde_pkg::REG_COEF_REAL:
                begin
                    coef_real_reg <= cfg.data;
                end
                pde_pkg::REG_COEF_IMAG:
                begin
                    coef_imag_reg <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances while the skid is empty
    // ------------------------------------------------------------------
    logic skid_full_reg;
    logic signed [pde_pkg::PHASE_W-1:0] skid_phase_reg;
    logic en;

    assign en              = !skid_full_reg;
    assign sample_in.ready = en;

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [NS:0] cv_reg;        // CORDIC stage valid, index 0 = after setup
    logic out_v_reg;

    // ------------------------------------------------------------------
    // Stage 1: the four sample products
    // ------------------------------------------------------------------
    logic signed [MW-1:0] m_rrsr_reg, m_risi_reg, m_risr_reg, m_rrsi_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_rrsr_reg <= sample_in.ref_real * sample_in.sig_real;
            m_risi_reg <= sample_in.ref_imag * sample_in.sig_imag;
            m_risr_reg <= sample_in.ref_imag * sample_in.sig_real;
            m_rrsi_reg <= sample_in.ref_real * sample_in.sig_imag;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: conjugate product P = R * conj(S), floor-shifted for wide
    // samples
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum_r, sum_i, sh_r, sh_i;
    logic signed [PW-1:0] pr_reg, pi_reg;

    always_comb
    begin
        sum_r = SW'(m_rrsr_reg) + SW'(m_risi_reg);
        sum_i = SW'(m_risr_reg) - SW'(m_rrsi_reg);
        sh_r  = sum_r >>> PS;
        sh_i  = sum_i >>> PS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg <= sh_r[PW-1:0];
            pi_reg <= sh_i[PW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: products with the coefficient
    // ------------------------------------------------------------------
    logic signed [CMW-1:0] p_rc_reg, p_ic_reg, p_rci_reg, p_icr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rc_reg  <= pr_reg * coef_real_reg;
            p_ic_reg  <= pi_reg * coef_imag_reg;
            p_rci_reg <= pr_reg * coef_imag_reg;
            p_icr_reg <= pi_reg * coef_real_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rotated vector Q = P * C
    // ------------------------------------------------------------------
    logic signed [QW-1:0] qr_reg, qi_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qr_reg <= QW'(p_rc_reg) - QW'(p_ic_reg);
            qi_reg <= QW'(p_rci_reg) + QW'(p_icr_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5 and CORDIC: fold the left half-plane, then one micro-rotation
    // per stage
    // ------------------------------------------------------------------
    logic signed [XW-1:0] x_reg [0:NS];
    logic signed [XW-1:0] y_reg [0:NS];
    logic [pde_pkg::Z_W-1:0] z_reg [0:NS];
    logic [NS:0] zf_reg;        // vector was exactly zero

    logic signed [XW-1:0] x_next [0:NS];
    logic signed [XW-1:0] y_next [0:NS];
    logic [pde_pkg::Z_W-1:0] z_next [0:NS];
    logic signed [XW-1:0] qr_ext, qi_ext;

    always_comb
    begin
        qr_ext = XW'(qr_reg);
        qi_ext = XW'(qi_reg);
        if (qr_reg < 0)
        begin
            x_next[0] = -qr_ext;
            y_next[0] = -qi_ext;
            z_next[0] = pde_pkg::Z_PI;
        end
        else
        begin
            x_next[0] = qr_ext;
            y_next[0] = qi_ext;
            z_next[0] = pde_pkg::Z_ZERO;
        end
        for (int k = 0; k < NS; k++)
        begin
            if (!y_reg[k][XW-1])
            begin
                x_next[k+1] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] + pde_pkg::ATAN_TAB[k];
            end
            else
            begin
                x_next[k+1] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k+1] = z_reg[k] - pde_pkg::ATAN_TAB[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            zf_reg <= {zf_reg[NS-1:0], (qr_reg == '0) && (qi_reg == '0)};
        end
    end

    // ------------------------------------------------------------------
    // Output stage: round half up to 16 bits; force zero for a null vector
    // ------------------------------------------------------------------
    logic [pde_pkg::Z_W-1:0] z_round;
    logic signed [pde_pkg::PHASE_W-1:0] phase_reg;

    assign z_round = z_reg[NS] + pde_pkg::ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zf_reg[NS])
            begin
                phase_reg <= '0;
            end
            else
            begin
                phase_reg <= z_round[pde_pkg::Z_W-1 -: pde_pkg::PHASE_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid bits travel with the data
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            cv_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= sample_in.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            cv_reg    <= {cv_reg[NS-1:0], v4_reg};
            out_v_reg <= cv_reg[NS];
        end
    end

    // ------------------------------------------------------------------
    // Output skid: catch the result the receiver refuses, hold the pipe
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (phase_out.ready)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (out_v_reg && !phase_out.ready)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && out_v_reg && !phase_out.ready)
        begin
            skid_phase_reg <= phase_reg;
        end
    end

    assign phase_out.valid = skid_full_reg || out_v_reg;
    assign phase_out.phase = skid_full_reg ? skid_phase_reg : phase_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_v_reg && !phase_out.ready))
        else $error("skid filled without a refused result");

    a_pipe_holds_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |=> ($stable(phase_reg) && $stable(out_v_reg)))
        else $error("pipeline moved while the skid was full");

    a_cordic_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (cv_reg[NS] && !zf_reg[NS]) |-> !x_reg[NS][XW-1])
        else $error("CORDIC magnitude went negative");

    a_zero_vector_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $past(en && cv_reg[NS] && zf_reg[NS]) |-> (out_v_reg && (phase_reg == '0)))
        else $error("null vector gave a non-zero phase");

endmodule
